[hdl/assert_macros.svh]
// Assertion helpers for the sprite blitter RTL.
// Each check is compiled away in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TLSB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tlsb assertion failed");
`define TLSB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tlsb implication failed");
`else
`define TLSB_ASSERT(lbl, clk, rstn, prop)
`define TLSB_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

[hdl/tlsb_pkg.sv]
// ---------------------------------------------------------------------------
// tlsb_pkg
// Shared types, request codes and blend tables for the two-layer blitter.
// ---------------------------------------------------------------------------
`default_nettype none
package tlsb_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int SPR_SIZE       = 8;

  // request codes
  localparam logic [2:0] REQ_READ  = 3'd0;
  localparam logic [2:0] REQ_WRITE = 3'd1;
  localparam logic [2:0] REQ_SPR1  = 3'd2;
  localparam logic [2:0] REQ_SPR2  = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  localparam logic [3:0] FG_MASK = 4'hc;

  // blend rows for pixel values 0..3, and opacity row
  localparam logic [1:0] BLEND_TAB [4][16] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1,
      2'd2, 2'd2, 2'd0, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
      2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1,
      2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1},
    '{2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2,
      2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2}};
  localparam logic [15:0] OPA_ROW = 16'h7bdf;

  typedef struct packed {
    logic [2:0]  req_type;
    logic        layer_sel;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [3:0]  color_code;
    logic        flip_x;
    logic        flip_y;
    logic [63:0] plane_low;
    logic [63:0] plane_high;
  } in_t;

  typedef struct packed {
    logic [1:0] read_color;
    logic       changed;
  } out_t;

  // one nibble update found by a lane
  typedef struct packed {
    logic       en;
    logic [1:0] val;
  } lane_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_ROW, S_BYTE, S_CLR, S_DRAIN, S_DONE
  } state_t;

endpackage
`default_nettype wire

[hdl/two_layer_sprite_blitter.sv]
// ---------------------------------------------------------------------------
// two_layer_sprite_blitter
// Two-layer frame store with pixel access, 8x8 sprite blits and clear.
//
//  channel | ports                          | handshake
//  input   | start, busy, in_data           | beat taken when start & !busy
//  result  | out_valid, out_data            | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | valid & ready
//
// Pixel read or write: one row setup and one byte slot. Sprite: 8 rows of
// (1 row setup + 5 byte slots); the single store read port feeds
// one byte per cycle to the two pixel lanes.
// Clear: width/2 * height bytes, one byte per cycle.
// After reset and after every width or height register write a clearing
// pass over all MAX_WIDTH*MAX_HEIGHT/2 store bytes runs with busy high.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module two_layer_sprite_blitter #(
  parameter int MAX_WIDTH  = tlsb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tlsb_pkg::MAX_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tlsb_pkg::in_t  in_data,
  output logic           out_valid,
  output tlsb_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [9:0]     cfg_data
);
  import tlsb_pkg::*;

  localparam int WW          = $clog2(MAX_WIDTH + 1);
  localparam int HW          = $clog2(MAX_HEIGHT + 1);
  localparam int STORE_BYTES = MAX_WIDTH * MAX_HEIGHT / 2;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CW          = AW + 1;
  localparam logic [10:0] W_CAP = 11'(MAX_WIDTH / 2 * 2);
  localparam logic [10:0] H_CAP = 11'(MAX_HEIGHT);
  localparam logic [CW-1:0] INIT_LAST = CW'(STORE_BYTES - 1);

  state_t        state_r, state_nxt;
  logic [9:0]    cfg_w_r, cfg_w_nxt;
  logic [9:0]    cfg_h_r, cfg_h_nxt;
  in_t           req_r, req_nxt;
  logic [2:0]    e_r, e_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [AW-1:0] row_base_r, row_base_nxt;
  logic          row_ok_r, row_ok_nxt;
  logic [7:0]    rlo_r, rlo_nxt;
  logic [7:0]    rhi_r, rhi_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cl_n_r, cl_n_nxt;
  // byte pipeline stage
  logic          pa_vld_r, pa_vld_nxt;
  logic          pa_rd_r, pa_rd_nxt;
  logic          pa_clr_r, pa_clr_nxt;
  logic          pa_nib_r, pa_nib_nxt;
  logic [AW-1:0] pa_addr_r, pa_addr_nxt;
  lane_t         pa_even_r, pa_even_nxt;
  lane_t         pa_odd_r, pa_odd_nxt;
  logic [1:0]    rd_r, rd_nxt;
  logic          chg_r, chg_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;

  logic          cfg_fire;
  logic          accept;
  logic [10:0]   w_even, h_ext, eff_w, eff_h;
  logic [WW-2:0] stride;
  logic [15:0]   eff_w16, eff_h16;
  logic [15:0]   y_cur;
  logic [HW+WW-2:0] row_prod;
  logic [CW-1:0] area_prod;
  logic [2:0]    v_sel;
  logic [14:0]   bc;
  logic [AW-1:0] byte_addr;
  logic          is_spr;
  logic [2:0]    k_last, e_last;
  lane_t         even_res, odd_res;
  logic [7:0]    new_byte;
  logic          m_chg;
  logic [3:0]    pix;
  logic          st_rd_en, st_wr_en;
  logic [AW-1:0] st_rd_addr, st_wr_addr;
  logic [7:0]    st_rd_data, st_wr_data;

  // effective geometry
  always_comb begin
    w_even    = {1'b0, cfg_w_r[9:1], 1'b0};
    h_ext     = {1'b0, cfg_h_r};
    eff_w     = (w_even > W_CAP) ? W_CAP : w_even;
    eff_h     = (h_ext > H_CAP) ? H_CAP : h_ext;
    stride    = eff_w[WW-1:1];
    eff_w16   = 16'(eff_w);
    eff_h16   = 16'(eff_h);
    area_prod = CW'(stride * eff_h[HW-1:0]);
  end

  // a register write never shares an edge with an accepted beat
  assign cfg_ready = (state_r == S_INIT) || ((state_r == S_IDLE) && !start);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;

  // sweep position helpers
  always_comb begin
    is_spr    = (req_r.req_type == REQ_SPR1) || (req_r.req_type == REQ_SPR2);
    k_last    = is_spr ? 3'd4 : 3'd0;
    e_last    = is_spr ? 3'(SPR_SIZE - 1) : 3'd0;
    y_cur     = req_r.pos_y + 16'(e_r);
    row_prod  = y_cur[HW-1:0] * stride;
    v_sel     = req_r.flip_y ? ~e_r : e_r;
    bc        = req_r.pos_x[15:1] + 15'(k_r);
    byte_addr = row_base_r + AW'(bc);
  end

  // two pixel lanes, one per nibble of the byte
  tlsb_lane u_lane_even (
    .req    (req_r),
    .x      ({bc, 1'b0}),
    .y_ok   (row_ok_r),
    .eff_w  (eff_w16),
    .row_lo (rlo_r),
    .row_hi (rhi_r),
    .res    (even_res)
  );

  tlsb_lane u_lane_odd (
    .req    (req_r),
    .x      ({bc, 1'b1}),
    .y_ok   (row_ok_r),
    .eff_w  (eff_w16),
    .row_lo (rlo_r),
    .row_hi (rhi_r),
    .res    (odd_res)
  );

  tlsb_merge u_merge (
    .old_byte (st_rd_data),
    .layer    (req_r.layer_sel),
    .even_res (pa_even_r),
    .odd_res  (pa_odd_r),
    .new_byte (new_byte),
    .changed  (m_chg)
  );

  tlsb_store #(.DEPTH(STORE_BYTES)) u_store (
    .clk     (clk),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (cfg_fire) state_nxt = S_INIT;
        else if (cnt_r == INIT_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_fire && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)) begin
          state_nxt = S_INIT;
        end else if (accept) begin
          case (in_data.req_type)
            REQ_READ, REQ_WRITE, REQ_SPR1, REQ_SPR2: state_nxt = S_ROW;
            REQ_CLEAR: state_nxt = S_CLR;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_ROW:   state_nxt = S_BYTE;
      S_BYTE: begin
        if (k_r == k_last) state_nxt = (e_r == e_last) ? S_DRAIN : S_ROW;
      end
      S_CLR: begin
        if (cnt_r == cl_n_r) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and store controls
  always_comb begin
    cfg_w_nxt     = cfg_w_r;
    cfg_h_nxt     = cfg_h_r;
    req_nxt       = req_r;
    e_nxt         = e_r;
    k_nxt         = k_r;
    row_base_nxt  = row_base_r;
    row_ok_nxt    = row_ok_r;
    rlo_nxt       = rlo_r;
    rhi_nxt       = rhi_r;
    cnt_nxt       = cnt_r;
    cl_n_nxt      = cl_n_r;
    pa_vld_nxt    = 1'b0;
    pa_rd_nxt     = 1'b0;
    pa_clr_nxt    = 1'b0;
    pa_nib_nxt    = req_r.pos_x[0];
    pa_addr_nxt   = byte_addr;
    pa_even_nxt   = even_res;
    pa_odd_nxt    = odd_res;
    rd_nxt        = rd_r;
    chg_nxt       = chg_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    st_rd_en      = 1'b0;
    st_rd_addr    = byte_addr;
    st_wr_en      = 1'b0;
    st_wr_addr    = pa_addr_r;
    st_wr_data    = new_byte;
    pix           = pa_nib_r ? st_rd_data[3:0] : st_rd_data[7:4];

    // register writes
    if (cfg_fire) begin
      if (cfg_index == CFG_WIDTH)  cfg_w_nxt = cfg_data;
      if (cfg_index == CFG_HEIGHT) cfg_h_nxt = cfg_data;
      cnt_nxt = '0;
    end

    case (state_r)
      S_INIT: begin
        st_wr_en   = 1'b1;
        st_wr_addr = cnt_r[AW-1:0];
        st_wr_data = 8'h00;
        if (!cfg_fire) cnt_nxt = cnt_r + CW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt  = in_data;
          e_nxt    = '0;
          k_nxt    = '0;
          cnt_nxt  = '0;
          cl_n_nxt = area_prod;
          rd_nxt   = '0;
          chg_nxt  = 1'b0;
        end
      end
      S_ROW: begin
        row_ok_nxt   = (y_cur < eff_h16);
        row_base_nxt = AW'(row_prod);
        rlo_nxt      = req_r.plane_low[v_sel*8 +: 8];
        rhi_nxt      = req_r.plane_high[v_sel*8 +: 8];
        k_nxt        = '0;
      end
      S_BYTE: begin
        // issue one store read for this byte slot if it is valid
        if (req_r.req_type == REQ_READ) begin
          pa_vld_nxt = row_ok_r && (req_r.pos_x < eff_w16);
          pa_rd_nxt  = 1'b1;
        end else begin
          pa_vld_nxt = even_res.en || odd_res.en;
        end
        st_rd_en = pa_vld_nxt;
        k_nxt    = k_r + 3'd1;
        if (k_r == k_last) e_nxt = e_r + 3'd1;
      end
      S_CLR: begin
        if (cnt_r != cl_n_r) begin
          st_rd_en    = 1'b1;
          st_rd_addr  = cnt_r[AW-1:0];
          pa_vld_nxt  = 1'b1;
          pa_clr_nxt  = 1'b1;
          cnt_nxt     = cnt_r + CW'(1);
        end
      end
      S_DONE: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.read_color = rd_r;
        out_data_nxt.changed    = chg_r;
      end
      default: ;
    endcase

    // second stage: merge and write back, read reply or clear check
    if (pa_vld_r) begin
      if (pa_clr_r) begin
        chg_nxt    = chg_r | (st_rd_data != 8'h00);
        st_wr_en   = 1'b1;
        st_wr_addr = cnt_r[AW-1:0];
        st_wr_data = 8'h00;
      end else if (pa_rd_r) begin
        rd_nxt = ((pix & FG_MASK) != 4'h0) ? pix[3:2] : pix[1:0];
      end else begin
        st_wr_en = 1'b1;
        chg_nxt  = chg_r | m_chg;
      end
    end
    // clear sweep writes its zero in the issue cycle
    if (state_r == S_CLR && cnt_r != cl_n_r) begin
      st_wr_en   = 1'b1;
      st_wr_addr = cnt_r[AW-1:0];
      st_wr_data = 8'h00;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cfg_w_r     <= 10'd512;
      cfg_h_r     <= 10'd320;
      cnt_r       <= '0;
      pa_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_w_r     <= cfg_w_nxt;
      cfg_h_r     <= cfg_h_nxt;
      cnt_r       <= cnt_nxt;
      pa_vld_r    <= pa_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    e_r        <= e_nxt;
    k_r        <= k_nxt;
    row_base_r <= row_base_nxt;
    row_ok_r   <= row_ok_nxt;
    rlo_r      <= rlo_nxt;
    rhi_r      <= rhi_nxt;
    cl_n_r     <= cl_n_nxt;
    pa_rd_r    <= pa_rd_nxt;
    pa_clr_r   <= pa_clr_nxt;
    pa_nib_r   <= pa_nib_nxt;
    pa_addr_r  <= pa_addr_nxt;
    pa_even_r  <= pa_even_nxt;
    pa_odd_r   <= pa_odd_nxt;
    rd_r       <= rd_nxt;
    chg_r      <= chg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `TLSB_ASSERT_IMPL(a_idle_pipe_empty, clk, rst_n, state_r == S_IDLE, !pa_vld_r)
  `TLSB_ASSERT_IMPL(a_strobe_after_done, clk, rst_n, out_valid_r, $past(state_r) == S_DONE)
  `TLSB_ASSERT(a_accept_goes_busy, clk, rst_n, accept |=> busy)
  `TLSB_ASSERT_IMPL(a_init_no_pipe, clk, rst_n, state_r == S_INIT, !pa_vld_r)

endmodule
`default_nettype wire

[hdl/tlsb_lane.sv]
// ---------------------------------------------------------------------------
// tlsb_lane
// Works out the update for one pixel column of the current byte.
// ---------------------------------------------------------------------------
`default_nettype none
module tlsb_lane (
  input  tlsb_pkg::in_t   req,
  input  logic [15:0]     x,
  input  logic            y_ok,
  input  logic [15:0]     eff_w,
  input  logic [7:0]      row_lo,
  input  logic [7:0]      row_hi,
  output tlsb_pkg::lane_t res
);
  import tlsb_pkg::*;

  logic [15:0] d;
  logic [2:0]  h;
  logic [1:0]  c;
  logic        hit;
  logic        in_x;

  always_comb begin
    d    = x - req.pos_x;
    hit  = (d < 16'(SPR_SIZE));
    h    = req.flip_x ? ~d[2:0] : d[2:0];
    // row bit 7 is the left pixel
    c    = {(req.req_type == REQ_SPR2) & row_hi[~h], row_lo[~h]};
    in_x = (x < eff_w) && y_ok;
    res  = '0;
    if (req.req_type == REQ_WRITE) begin
      res.en  = in_x && (x == req.pos_x);
      res.val = req.color_code[1:0];
    end else begin
      res.en  = in_x && hit && !((c == 2'd0) && !OPA_ROW[req.color_code]);
      res.val = BLEND_TAB[c][req.color_code];
    end
  end

endmodule
`default_nettype wire

[hdl/tlsb_merge.sv]
// ---------------------------------------------------------------------------
// tlsb_merge
// Folds the two lane updates into the stored byte and flags a change.
// ---------------------------------------------------------------------------
`default_nettype none
module tlsb_merge (
  input  logic [7:0]      old_byte,
  input  logic            layer,
  input  tlsb_pkg::lane_t even_res,
  input  tlsb_pkg::lane_t odd_res,
  output logic [7:0]      new_byte,
  output logic            changed
);
  import tlsb_pkg::*;

  logic [3:0] hi_n;
  logic [3:0] lo_n;

  always_comb begin
    hi_n = old_byte[7:4];
    lo_n = old_byte[3:0];
    // even pixel lives in the high nibble
    if (even_res.en) begin
      if (layer) hi_n[3:2] = even_res.val;
      else       hi_n[1:0] = even_res.val;
    end
    if (odd_res.en) begin
      if (layer) lo_n[3:2] = odd_res.val;
      else       lo_n[1:0] = odd_res.val;
    end
    new_byte = {hi_n, lo_n};
    changed  = (new_byte != old_byte);
  end

endmodule
`default_nettype wire

[hdl/tlsb_store.sv]
// ---------------------------------------------------------------------------
// tlsb_store
// Frame store: one write port, one registered read port, read-first.
// ---------------------------------------------------------------------------
`default_nettype none
module tlsb_store #(
  parameter  int DEPTH = tlsb_pkg::MAX_WIDTH_DEF * tlsb_pkg::MAX_HEIGHT_DEF / 2,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);
  import tlsb_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[sim/two_layer_sprite_blitter_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// two_layer_sprite_blitter_tb
// Drives pixel reads and writes, sprite blits and clears through the command
// port, checks every result strobe against a local frame store model, and
// resizes the screen between phases (the extremes among them).
// ---------------------------------------------------------------------------
module two_layer_sprite_blitter_tb;
  import tlsb_pkg::*;

  localparam int STORE_BYTES = 131072;
  localparam int IDLE_LIMIT  = 400000;

  logic clk, rst_n;
  logic start, busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;

  two_layer_sprite_blitter dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // blend rows 0..3 and the opacity row
  bit [1:0] blend_rows [4][16] = '{
    '{0, 0, 0, 0, 1, 0, 1, 1, 2, 2, 0, 2, 3, 3, 3, 0},
    '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3},
    '{1, 2, 3, 1, 1, 2, 3, 1, 1, 2, 3, 1, 1, 2, 3, 1},
    '{2, 3, 1, 2, 2, 3, 1, 2, 2, 3, 1, 2, 2, 3, 1, 2}};
  bit opaque [16] = '{1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 0, 1, 1, 1, 1, 0};

  // model state
  bit [7:0] pixel_bytes [STORE_BYTES];
  bit [9:0] scr_width, scr_height;

  in_t  pending_reqs [$];
  out_t expected_results [$];
  int   fail_count;
  int   idle_cycles;

  function automatic int act_width();
    int w;
    w = scr_width & 10'h3fe;
    return (w > 512) ? 512 : w;
  endfunction

  function automatic int act_height();
    return (scr_height > 512) ? 512 : scr_height;
  endfunction

  function automatic bit on_screen(bit [15:0] x, bit [15:0] y);
    return x < act_width() && y < act_height();
  endfunction

  function automatic int byte_addr(bit [15:0] x, bit [15:0] y);
    return (int'(y) * (act_width() / 2) + int'(x) / 2) % STORE_BYTES;
  endfunction

  function automatic bit plot(bit layer, bit [15:0] x, bit [15:0] y, bit [1:0] c);
    int a, sh;
    bit [7:0] old_b, new_b;
    if (!on_screen(x, y)) return 0;
    a = byte_addr(x, y);
    sh = (x[0] ? 0 : 4) + (layer ? 2 : 0);
    old_b = pixel_bytes[a];
    new_b = (old_b & ~(8'h3 << sh)) | (8'(c) << sh);
    pixel_bytes[a] = new_b;
    return old_b != new_b;
  endfunction

  function automatic void wipe_store();
    foreach (pixel_bytes[i]) pixel_bytes[i] = 0;
  endfunction

  // apply one request to the model, return the expected result
  function automatic out_t blit_predict(in_t r);
    out_t res;
    bit [7:0] b, lo, hi;
    bit [3:0] pix;
    bit [1:0] c;
    int n;
    res = '0;
    case (r.req_type)
      REQ_READ: begin
        if (on_screen(r.pos_x, r.pos_y)) begin
          b = pixel_bytes[byte_addr(r.pos_x, r.pos_y)];
          pix = r.pos_x[0] ? b[3:0] : b[7:4];
          res.read_color = (pix & FG_MASK) ? pix[3:2] : pix[1:0];
        end
      end
      REQ_WRITE: res.changed = plot(r.layer_sel, r.pos_x, r.pos_y, r.color_code[1:0]);
      REQ_SPR1, REQ_SPR2: begin
        for (int v = 0; v < 8; v++) begin
          lo = r.plane_low[8*v +: 8];
          hi = r.plane_high[8*v +: 8];
          for (int h = 0; h < 8; h++) begin
            c = {(r.req_type == REQ_SPR2) ? hi[7-h] : 1'b0, lo[7-h]};
            if (c == 0 && !opaque[r.color_code]) continue;
            if (plot(r.layer_sel, r.pos_x + 16'(r.flip_x ? 7 - h : h),
                     r.pos_y + 16'(r.flip_y ? 7 - v : v), blend_rows[c][r.color_code]))
              res.changed = 1;
          end
        end
      end
      REQ_CLEAR: begin
        n = act_width() / 2 * act_height();
        for (int i = 0; i < n; i++) begin
          if (pixel_bytes[i] != 0) res.changed = 1;
          pixel_bytes[i] = 0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // request driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_data <= '0;
    end else begin
      if (start && !busy) expected_results.push_back(blit_predict(in_data));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 0;
        end else if (pending_reqs.size() > 0) begin
          in_data <= pending_reqs.pop_front();
          start <= 1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result strobe with nothing outstanding");
      end else begin
        want = expected_results.pop_front();
        if (out_data.read_color !== want.read_color)
          report_mismatch($sformatf("read_color %0d, want %0d",
                                    out_data.read_color, want.read_color));
        if (out_data.changed !== want.changed)
          report_mismatch($sformatf("changed %0d, want %0d",
                                    out_data.changed, want.changed));
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  function automatic bit [15:0] pick_coord(int span);
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'hfff0 | 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, span + 4));
    endcase
  endfunction

  function automatic in_t rand_req(bit clears_ok);
    in_t r;
    int sel;
    r = '0;
    r.layer_sel = 1'($urandom);
    r.pos_x = pick_coord(act_width());
    r.pos_y = pick_coord(act_height());
    r.color_code = 4'($urandom);
    r.flip_x = 1'($urandom);
    r.flip_y = 1'($urandom);
    r.plane_low = {$urandom, $urandom};
    r.plane_high = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 30) r.req_type = REQ_READ;
    else if (sel < 60) r.req_type = REQ_WRITE;
    else if (sel < 76) r.req_type = REQ_SPR1;
    else if (sel < 92) r.req_type = REQ_SPR2;
    else if (sel < 96 && clears_ok) r.req_type = REQ_CLEAR;
    else if (sel < 96) r.req_type = REQ_READ;
    else r.req_type = 3'($urandom_range(5, 7));
    return r;
  endfunction

  function automatic in_t mk(bit [2:0] kind, bit layer, bit [15:0] x, bit [15:0] y,
                             bit [3:0] col, bit fx, bit fy, bit [63:0] pl, bit [63:0] ph);
    in_t r;
    r.req_type = kind; r.layer_sel = layer; r.pos_x = x; r.pos_y = y;
    r.color_code = col; r.flip_x = fx; r.flip_y = fy;
    r.plane_low = pl; r.plane_high = ph;
    return r;
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || start)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(bit [1:0] idx, bit [9:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == CFG_WIDTH) scr_width = val;
    else if (idx == CFG_HEIGHT) scr_height = val;
    if (idx == CFG_WIDTH || idx == CFG_HEIGHT) wipe_store();
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    bit small_area;
    small_area = act_width() / 2 * act_height() <= 2048;
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req(small_area));
    drain();
  endtask

  // stimulus sequence
  initial begin
    rst_n = 0;
    cfg_valid = 0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    fail_count = 0;
    scr_width = 512;
    scr_height = 320;
    wipe_store();
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // directed: layers, visibility, area edges, sprites, odd codes, clear
    pending_reqs.push_back(mk(REQ_WRITE, 0, 0, 0, 3, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 1, 1, 0, 2, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 1, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 1, 0, 0, 1, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 1, 0, 0, 4'hc, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 0, 512, 5, 3, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 0, 5, 320, 3, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 1, 16'hffff, 16'hffff, 3, 1, 1, '1, '1));
    pending_reqs.push_back(mk(REQ_READ, 1, 511, 319, 0, 1, 1, '1, '1));
    pending_reqs.push_back(mk(REQ_READ, 0, 512, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_SPR1, 0, 16, 16, 0, 0, 0, '1, 0));
    pending_reqs.push_back(mk(REQ_SPR1, 1, 32, 16, 5, 0, 0, 0, '1));
    pending_reqs.push_back(mk(REQ_SPR1, 1, 48, 16, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_SPR2, 0, 16'hfffc, 16'hfffc, 15, 1, 1,
                              64'h0123456789abcdef, 64'hfedcba9876543210));
    pending_reqs.push_back(mk(REQ_SPR2, 1, 508, 316, 9, 1, 0, '1, '1));
    pending_reqs.push_back(mk(REQ_READ, 0, 509, 317, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(3'd5, 1, 3, 3, 15, 1, 1, '1, '1));
    pending_reqs.push_back(mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(3'd7, 1, 0, 0, 1, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 1, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_CLEAR, 1, 16'hffff, 16'hffff, 15, 1, 1, '1, '1));
    drain();
    random_phase(200);

    // small screen, clears allowed
    reg_write(CFG_WIDTH, 10'd40);
    reg_write(CFG_HEIGHT, 10'd24);
    random_phase(400);

    // unused register index leaves everything alone
    reg_write(2'd3, 10'h3ff);
    random_phase(50);

    // zero width, tallest height: nothing is on screen
    reg_write(CFG_WIDTH, 10'd0);
    reg_write(CFG_HEIGHT, 10'd512);
    random_phase(100);

    // oversized geometry saturates; odd width rounds down
    reg_write(CFG_WIDTH, 10'h3ff);
    reg_write(CFG_HEIGHT, 10'h3ff);
    random_phase(150);

    reg_write(CFG_WIDTH, 10'd17);
    reg_write(CFG_HEIGHT, 10'd9);
    random_phase(300);

    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/tlsb_pkg.sv
hdl/tlsb_lane.sv
hdl/tlsb_merge.sv
hdl/tlsb_store.sv
hdl/two_layer_sprite_blitter.sv
sim/two_layer_sprite_blitter_tb.sv
